### src/pid_dist_pkg.sv
package pid_dist_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACCUM_WIDTH_DEF  = 32;

    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int ENABLE_W   = 4;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int TEN_VOLTS  = 10240;

    // enable_mask bit positions
    localparam int EN_P    = 0;
    localparam int EN_I    = 1;
    localparam int EN_D    = 2;
    localparam int EN_DIST = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DISTURB_START  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISTURB_LENGTH = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DISTURB_LEVEL  = 4'd7;

    // reset values
    localparam logic [GAIN_W-1:0]   GAIN_P_RST      = 16'd8602;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST      = 16'd4506;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST      = 16'd4506;
    localparam logic [ENABLE_W-1:0] ENABLE_MASK_RST = 4'd7;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [ENABLE_W-1:0] enable_mask;
        logic [TICK_W-1:0]   disturb_start;
        logic [TICK_W-1:0]   disturb_length;
    } t_ctl_cfg;

endpackage

### src/pid_dist_cfg.sv
module pid_dist_cfg import pid_dist_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int CFG_W        = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [CFG_IDX_W-1:0]           i_index,
    input  logic [CFG_W-1:0]               i_data,
    output t_ctl_cfg                       o_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_setpoint,
    output logic signed [SAMPLE_WIDTH-1:0] o_disturb_level
);

    t_ctl_cfg                       r_ctl;
    logic signed [SAMPLE_WIDTH-1:0] r_setpoint;
    logic signed [SAMPLE_WIDTH-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.gain_p         <= GAIN_P_RST;
            r_ctl.gain_i         <= GAIN_I_RST;
            r_ctl.gain_d         <= GAIN_D_RST;
            r_ctl.enable_mask    <= ENABLE_MASK_RST;
            r_ctl.disturb_start  <= '0;
            r_ctl.disturb_length <= '0;
            r_setpoint           <= '0;
            r_level              <= '0;
        end else if (i_wr) begin
            case (i_index)
                REG_SETPOINT:       r_setpoint           <= i_data[SAMPLE_WIDTH-1:0];
                REG_GAIN_P:         r_ctl.gain_p         <= i_data[GAIN_W-1:0];
                REG_GAIN_I:         r_ctl.gain_i         <= i_data[GAIN_W-1:0];
                REG_GAIN_D:         r_ctl.gain_d         <= i_data[GAIN_W-1:0];
                REG_ENABLE_MASK:    r_ctl.enable_mask    <= i_data[ENABLE_W-1:0];
                REG_DISTURB_START:  r_ctl.disturb_start  <= i_data[TICK_W-1:0];
                REG_DISTURB_LENGTH: r_ctl.disturb_length <= i_data[TICK_W-1:0];
                REG_DISTURB_LEVEL:  r_level              <= i_data[SAMPLE_WIDTH-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_ctl           = r_ctl;
    assign o_setpoint      = r_setpoint;
    assign o_disturb_level = r_level;

endmodule

### src/pid_dist_core.sv
module pid_dist_core import pid_dist_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ACCUM_WIDTH  = ACCUM_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured,
    input  logic                           i_restart,
    input  logic signed [SAMPLE_WIDTH-1:0] i_setpoint,
    input  t_ctl_cfg                       i_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_drive,
    output logic signed [SAMPLE_WIDTH:0]   o_error,
    output logic                           o_clamped
);

    localparam int ErrW  = SAMPLE_WIDTH + 1;
    localparam int DiffW = SAMPLE_WIDTH + 2;
    localparam int IsumW = ((ACCUM_WIDTH > ErrW) ? ACCUM_WIDTH : ErrW) + 1;
    localparam int PpW   = GAIN_W + 1 + ErrW;
    localparam int IpW   = GAIN_W + 1 + ACCUM_WIDTH;
    localparam int DpW   = GAIN_W + 1 + DiffW;
    localparam int MaxPW = (IpW > PpW) ? ((IpW > DpW) ? IpW : DpW) : ((PpW > DpW) ? PpW : DpW);
    localparam int SumW  = MaxPW + 2;
    localparam int SMax  = (2 ** (SAMPLE_WIDTH - 1)) - 1;
    localparam int DriveTop = (TEN_VOLTS < SMax) ? TEN_VOLTS : SMax;
    localparam int DriveMin = -(2 ** (SAMPLE_WIDTH - 1));
    localparam logic signed [SumW-1:0] TOP_S = SumW'(DriveTop);
    localparam logic signed [SumW-1:0] MIN_S = SumW'(DriveMin);
    localparam logic signed [ACCUM_WIDTH-1:0] AMAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    localparam logic signed [ACCUM_WIDTH-1:0] AMIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

    logic signed [ACCUM_WIDTH-1:0] r_integral;
    logic signed [ErrW-1:0]        r_prev_err;

    logic signed [ACCUM_WIDTH-1:0] integ_base;
    logic signed [ErrW-1:0]        prev_base;
    logic signed [ErrW-1:0]        err;
    logic signed [IsumW-1:0]       isum;
    logic                          isum_fits;
    logic signed [ACCUM_WIDTH-1:0] n_integral;
    logic signed [DiffW-1:0]       diff;
    logic signed [GAIN_W:0]        gp_s;
    logic signed [GAIN_W:0]        gi_s;
    logic signed [GAIN_W:0]        gd_s;
    logic signed [PpW-1:0]         prod_p;
    logic signed [IpW-1:0]         prod_i;
    logic signed [DpW-1:0]         prod_d;
    logic signed [SumW-1:0]        term_p;
    logic signed [SumW-1:0]        term_i;
    logic signed [SumW-1:0]        term_d;
    logic signed [SumW-1:0]        sum;
    logic signed [SumW-1:0]        quot;
    logic signed [SumW-1:0]        drive_full;

    // restart zeroes the state ahead of this sample
    assign integ_base = i_restart ? '0 : r_integral;
    assign prev_base  = i_restart ? '0 : r_prev_err;

    assign err  = ErrW'(i_setpoint) - ErrW'(i_measured);
    assign isum = IsumW'(integ_base) + IsumW'(err);

    // fits when every bit above the accumulator sign matches it
    assign isum_fits = (isum[IsumW-1:ACCUM_WIDTH-1] == '0) ||
                       (isum[IsumW-1:ACCUM_WIDTH-1] == '1);
    assign n_integral = isum_fits ? isum[ACCUM_WIDTH-1:0] :
                        (isum[IsumW-1] ? AMIN : AMAX);

    assign diff = DiffW'(err) - DiffW'(prev_base);

    assign gp_s = {1'b0, i_ctl.gain_p};
    assign gi_s = {1'b0, i_ctl.gain_i};
    assign gd_s = {1'b0, i_ctl.gain_d};

    assign prod_p = gp_s * err;
    assign prod_i = gi_s * n_integral;
    assign prod_d = gd_s * diff;

    assign term_p = i_ctl.enable_mask[EN_P] ? SumW'(prod_p) : '0;
    assign term_i = i_ctl.enable_mask[EN_I] ? SumW'(prod_i) : '0;
    assign term_d = i_ctl.enable_mask[EN_D] ? SumW'(prod_d) : '0;

    // exact sum, floor shift back to volts
    assign sum  = term_p + term_i + term_d;
    assign quot = sum >>> GAIN_FRAC;

    always_comb begin
        o_clamped  = 1'b0;
        drive_full = quot;
        if (quot > TOP_S) begin
            drive_full = TOP_S;
            o_clamped  = 1'b1;
        end else if (quot < MIN_S) begin
            drive_full = MIN_S;
            o_clamped  = 1'b1;
        end
    end

    assign o_drive = drive_full[SAMPLE_WIDTH-1:0];
    assign o_error = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_advance) begin
            r_integral <= n_integral;
            r_prev_err <= err;
        end
    end

endmodule

### src/pid_dist_disturb.sv
module pid_dist_disturb import pid_dist_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic                           i_restart,
    input  logic                           i_enable,
    input  logic [TICK_W-1:0]              i_start,
    input  logic [TICK_W-1:0]              i_length,
    input  logic signed [SAMPLE_WIDTH-1:0] i_level,
    output logic signed [SAMPLE_WIDTH-1:0] o_disturb
);

    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] r_count;
    logic [TICK_W-1:0] tick_base;
    logic [TICK_W-1:0] count_base;
    logic              active;

    assign tick_base  = i_restart ? '0 : r_tick;
    assign count_base = i_restart ? '0 : r_count;

    // test uses the tick index before this tick's increment
    assign active    = i_enable && (tick_base > i_start) && (count_base < i_length);
    assign o_disturb = active ? i_level : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_count <= '0;
        end else if (i_advance) begin
            r_tick  <= (tick_base == '1) ? tick_base : tick_base + 1'b1;
            r_count <= active ? count_base + 1'b1 : count_base;
        end
    end

endmodule

### src/pid_controller_with_disturbance.sv
// A beat accepted into the input register passes through the core into the
// result register. Throughput: one beat per cycle while i_out_stall is low;
// single-pass datapath between the input register and the result register,
// state updated as each beat passes.
// Reset (i_rst_n low, synchronous): both pipeline registers empty, PID and
// disturbance state cleared, configuration back to its default values.
module pid_controller_with_disturbance import pid_dist_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ACCUM_WIDTH  = ACCUM_WIDTH_DEF,
    parameter int CFG_W        = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured,
    input  logic                           i_restart,

    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_drive,
    output logic signed [SAMPLE_WIDTH-1:0] o_disturb_out,
    output logic signed [SAMPLE_WIDTH:0]   o_error_value,
    output logic                           o_clamped,

    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]               i_cfg_data
);

    t_ctl_cfg                       ctl;
    logic signed [SAMPLE_WIDTH-1:0] setpoint;
    logic signed [SAMPLE_WIDTH-1:0] disturb_level;

    // input register
    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_measured;
    logic                           r_restart;

    // result register
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_drive;
    logic signed [SAMPLE_WIDTH-1:0] r_disturb;
    logic signed [SAMPLE_WIDTH:0]   r_error;
    logic                           r_clamped;

    logic                           advance;
    logic                           in_accept;
    logic signed [SAMPLE_WIDTH-1:0] drive;
    logic signed [SAMPLE_WIDTH:0]   error_val;
    logic                           clamped;
    logic signed [SAMPLE_WIDTH-1:0] disturb;

    // config writes are always taken; block is idle by contract
    assign o_cfg_ready = 1'b1;

    // the held beat moves on whenever the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    pid_dist_cfg #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CFG_W        (CFG_W)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (i_cfg_valid),
        .i_index         (i_cfg_index),
        .i_data          (i_cfg_data),
        .o_ctl           (ctl),
        .o_setpoint      (setpoint),
        .o_disturb_level (disturb_level)
    );

    pid_dist_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACCUM_WIDTH  (ACCUM_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_measured (r_measured),
        .i_restart  (r_restart),
        .i_setpoint (setpoint),
        .i_ctl      (ctl),
        .o_drive    (drive),
        .o_error    (error_val),
        .o_clamped  (clamped)
    );

    pid_dist_disturb #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_disturb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_restart (r_restart),
        .i_enable  (ctl.enable_mask[EN_DIST]),
        .i_start   (ctl.disturb_start),
        .i_length  (ctl.disturb_length),
        .i_level   (disturb_level),
        .o_disturb (disturb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_measured <= i_measured;
            r_restart  <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive   <= drive;
            r_disturb <= disturb;
            r_error   <= error_val;
            r_clamped <= clamped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_disturb_out = r_disturb;
    assign o_error_value = r_error;
    assign o_clamped     = r_clamped;

endmodule

### bench/pid_controller_with_disturbance_test.sv
`timescale 1ns / 100ps

module pid_controller_with_disturbance_test;
    import pid_dist_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 290;
    // burst lengths for the full-rate stretch: integrator up, then down
    localparam int SAT_RISE       = 40;
    localparam int SAT_FALL       = 40;
    localparam int MAX_REPORTS    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd12;

    localparam logic signed [15:0] S_MIN = 16'sh8000;
    localparam logic signed [15:0] S_MAX = 16'sh7fff;
    localparam longint ACC_MAX   = 64'sd2147483647;
    localparam longint ACC_MIN   = -ACC_MAX - 1;
    localparam longint DRIVE_MIN = -64'sd32768;

    typedef struct packed {
        logic signed [15:0] measured;
        logic               restart;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] drive;
        logic signed [15:0] disturb;
        logic signed [16:0] err;
        logic               clamped;
    } t_ctl_result;

    // ---------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ---------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic signed [15:0]    i_measured  = '0;
    logic                  i_restart   = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [15:0]    o_drive;
    logic signed [15:0]    o_disturb_out;
    logic signed [16:0]    o_error_value;
    logic                  o_clamped;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [15:0]           i_cfg_data  = '0;

    pid_controller_with_disturbance i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_measured    (i_measured),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive       (o_drive),
        .o_disturb_out (o_disturb_out),
        .o_error_value (o_error_value),
        .o_clamped     (o_clamped),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Controller model: register copy and loop state, at reset values
    // ---------------------------------------------------------------------
    logic signed [15:0]   ctl_setpoint = '0;
    logic [GAIN_W-1:0]    ctl_gain_p   = GAIN_P_RST;
    logic [GAIN_W-1:0]    ctl_gain_i   = GAIN_I_RST;
    logic [GAIN_W-1:0]    ctl_gain_d   = GAIN_D_RST;
    logic [ENABLE_W-1:0]  ctl_mask     = ENABLE_MASK_RST;
    logic [TICK_W-1:0]    dist_start   = '0;
    logic [TICK_W-1:0]    dist_len     = '0;
    logic signed [15:0]   dist_level   = '0;

    logic signed [31:0]   integ_acc    = '0;
    logic signed [16:0]   prev_err_m   = '0;
    logic [TICK_W-1:0]    tick_count   = '0;
    logic [TICK_W-1:0]    dist_ticks   = '0;

    // Bookkeeping shared between the processes; each counter has one writer.
    t_sample     sample_q[$];
    t_ctl_result drive_expect_q[$];
    int          samples_offered = 0;
    int          samples_taken   = 0;
    int          results_taken   = 0;
    int          cfg_taken       = 0;
    int          cycle_count     = 0;
    int          failures        = 0;
    bit          rush            = 1'b0;  // no idling on either side
    bit          hold_req        = 1'b0;  // toggled to ask for one long stall

    // One control tick: error, saturating integral, difference, weighted sum,
    // floor by 2^12, clamp, then the disturbance window and tick counter.
    function automatic t_ctl_result pid_tick(input logic signed [15:0] meas,
                                             input logic restart);
        t_ctl_result r;
        longint err_l, integ_l, diff_l, acc, scaled;
        if (restart) begin
            integ_acc  = '0;
            prev_err_m = '0;
            tick_count = '0;
            dist_ticks = '0;
        end
        err_l   = longint'(ctl_setpoint) - longint'(meas);
        integ_l = longint'(integ_acc) + err_l;
        if (integ_l > ACC_MAX) begin
            integ_l = ACC_MAX;
        end else if (integ_l < ACC_MIN) begin
            integ_l = ACC_MIN;
        end
        integ_acc = integ_l[31:0];
        diff_l    = err_l - longint'(prev_err_m);

        acc = 0;
        if (ctl_mask[EN_P]) acc += longint'(ctl_gain_p) * err_l;
        if (ctl_mask[EN_I]) acc += longint'(ctl_gain_i) * integ_l;
        if (ctl_mask[EN_D]) acc += longint'(ctl_gain_d) * diff_l;

        scaled    = acc >>> GAIN_FRAC;   // floor toward minus infinity
        r.clamped = 1'b0;
        if (scaled > TEN_VOLTS) begin
            scaled    = TEN_VOLTS;
            r.clamped = 1'b1;
        end else if (scaled < DRIVE_MIN) begin
            scaled    = DRIVE_MIN;
            r.clamped = 1'b1;
        end
        r.drive    = scaled[15:0];
        r.err      = err_l[16:0];
        prev_err_m = err_l[16:0];

        // window test sees the tick count before this tick's increment
        r.disturb = '0;
        if (ctl_mask[EN_DIST] && tick_count > dist_start && dist_ticks < dist_len) begin
            r.disturb  = dist_level;
            dist_ticks = dist_ticks + 1'b1;
        end
        if (tick_count != '1) tick_count = tick_count + 1'b1;
        return r;
    endfunction

    task automatic check_field(input string what, input logic signed [16:0] want_v,
                               input logic signed [16:0] got_v);
        if (got_v !== want_v) begin
            if (failures < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, what, want_v, got_v);
            failures++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ctl_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d of %0d samples taken, %0d results pending",
                     $time, samples_taken, samples_offered, drive_expect_q.size());
            $display("** pid_controller_with_disturbance: FAILED **");
            $finish;
        end else if (i_rst_n) begin
            // result beat
            if (o_out_valid && !i_out_stall) begin
                results_taken++;
                if (drive_expect_q.size() == 0) begin
                    if (failures < MAX_REPORTS)
                        $display("%0t ns: result beat with nothing expected, drive %0d",
                                 $time, o_drive);
                    failures++;
                end else begin
                    want = drive_expect_q.pop_front();
                    check_field("drive", want.drive, o_drive);
                    check_field("disturb_out", want.disturb, o_disturb_out);
                    check_field("error_value", want.err, o_error_value);
                    check_field("clamped", want.clamped, o_clamped);
                end
            end
            // sample beat: run the model tick right away
            if (i_in_valid && !o_in_stall) begin
                drive_expect_q.push_back(pid_tick(i_measured, i_restart));
                samples_taken++;
            end
            // register write; unmapped indexes leave everything alone
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SETPOINT:       ctl_setpoint = i_cfg_data;
                    REG_GAIN_P:         ctl_gain_p   = i_cfg_data;
                    REG_GAIN_I:         ctl_gain_i   = i_cfg_data;
                    REG_GAIN_D:         ctl_gain_d   = i_cfg_data;
                    REG_ENABLE_MASK:    ctl_mask     = i_cfg_data[ENABLE_W-1:0];
                    REG_DISTURB_START:  dist_start   = i_cfg_data;
                    REG_DISTURB_LENGTH: dist_len     = i_cfg_data;
                    REG_DISTURB_LEVEL:  dist_level   = i_cfg_data;
                    default: ;
                endcase
                cfg_taken++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sample driver: falling edge, random gap before each beat,
    // with calm stretches where beats go back to back
    // ---------------------------------------------------------------------
    int send_gap  = 0;
    int send_calm = 0;

    always @(negedge i_clk) begin
        logic    nxt_valid;
        t_sample cur;
        nxt_valid = i_in_valid;
        if (samples_offered == samples_taken) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (sample_q.size() > 0) begin
                cur = sample_q.pop_front();
                i_measured <= cur.measured;
                i_restart  <= cur.restart;
                nxt_valid  = 1'b1;
                samples_offered++;
                if (rush || send_calm > 0) begin
                    send_gap = 0;
                    if (send_calm > 0) send_calm--;
                end else if ($urandom_range(0, 15) == 0) begin
                    send_gap  = 0;
                    send_calm = $urandom_range(8, 64);
                end else begin
                    send_gap = $urandom_range(0, 14);
                end
            end
        end
        i_in_valid <= nxt_valid;
    end

    // ---------------------------------------------------------------------
    // Result receiver: stall drawn per beat, plus one long hold on request
    // ---------------------------------------------------------------------
    int  stall_left   = 0;
    int  recv_calm    = 0;
    int  results_seen = 0;
    bit  hold_ack     = 1'b0;

    always @(negedge i_clk) begin
        if (results_taken != results_seen) begin
            results_seen = results_taken;
            if (recv_calm > 0) begin
                recv_calm--;
                stall_left = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                recv_calm  = $urandom_range(8, 64);
                stall_left = 0;
            end else begin
                stall_left = $urandom_range(0, 14);
            end
        end
        if (rush) stall_left = 0;
        // long hold: pipeline fills and the sample side must back up
        if (hold_req != hold_ack) begin
            hold_ack   = hold_req;
            stall_left = LONG_HOLD;
        end
        i_out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    // ---------------------------------------------------------------------
    // Sequencer helpers
    // ---------------------------------------------------------------------
    task automatic queue_sample(input logic signed [15:0] meas, input logic restart);
        t_sample s;
        s.measured = meas;
        s.restart  = restart;
        sample_q.push_back(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        int target;
        target = cfg_taken + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (cfg_taken < target);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_all(input logic [15:0] sp, gp, gi, gd,
                               input logic [3:0] mask,
                               input logic [15:0] dstart, dlen, dlevel);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_ENABLE_MASK, {12'd0, mask});
        write_reg(REG_DISTURB_START, dstart);
        write_reg(REG_DISTURB_LENGTH, dlen);
        write_reg(REG_DISTURB_LEVEL, dlevel);
    endtask

    // wait for the block to go idle; one result per sample, so the last
    // result arriving means nothing is left in flight
    task automatic drain();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || samples_offered != samples_taken ||
               drive_expect_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------------
    initial begin
        int                 m;
        logic signed [15:0] sp;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Power-up gains: zero error, both full-scale errors (clamps at
        // 10 V and at the bottom), a restart, small errors.
        queue_sample(16'sd0, 1'b0);
        queue_sample(S_MIN, 1'b0);
        queue_sample(S_MAX, 1'b0);
        queue_sample(16'sd1, 1'b1);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd0, 1'b0);
        drain();

        // Full-range error, max P and D gains, three-tick disturbance at the
        // most negative level from tick 1 on; plus a write nobody decodes.
        program_all(S_MAX, 16'hffff, 16'h0000, 16'hffff, 4'hf, 16'd0, 16'd3, S_MIN);
        write_reg(REG_UNMAPPED, 16'hffff);
        queue_sample(S_MIN, 1'b1);
        queue_sample(S_MAX, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(-16'sd5, 1'b0);
        drain();

        // Each term alone, all terms off, then the disturbance enabled
        // with zero length.
        write_reg(REG_SETPOINT, S_MIN);
        write_reg(REG_ENABLE_MASK, 16'h0001);
        queue_sample(S_MAX, 1'b1);
        drain();
        write_reg(REG_ENABLE_MASK, 16'h0002);
        queue_sample(16'sd5, 1'b0);
        drain();
        write_reg(REG_ENABLE_MASK, 16'h0004);
        queue_sample(-16'sd7, 1'b0);
        drain();
        write_reg(REG_ENABLE_MASK, 16'h0000);
        queue_sample(16'sd123, 1'b0);
        drain();
        write_reg(REG_ENABLE_MASK, 16'h0008);
        write_reg(REG_DISTURB_LENGTH, 16'd0);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd0, 1'b0);
        drain();

        // Full-rate stretch: integral term driven hard up, then back down.
        // A start of 65535 must keep the disturbance away the whole time.
        rush = 1'b1;
        program_all(S_MAX, 16'd0, 16'hffff, 16'd0, 4'b1010, 16'hffff, 16'hffff, 16'sd1234);
        queue_sample(S_MIN, 1'b1);
        for (int k = 0; k < SAT_RISE; k++) queue_sample(S_MIN, 1'b0);
        drain();
        write_reg(REG_SETPOINT, S_MIN);
        for (int k = 0; k < SAT_FALL; k++) queue_sample(S_MAX, 1'b0);
        drain();
        // tick count now past a start of 60: four disturbed ticks, then off
        write_reg(REG_DISTURB_START, 16'd60);
        write_reg(REG_DISTURB_LENGTH, 16'd4);
        for (int k = 0; k < 6; k++) queue_sample(16'sd0, 1'b0);
        drain();
        rush = 1'b0;

        // Random phases: fresh settings each time, mostly samples near the
        // setpoint so the loop is not always clamped, some full-range noise.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sp = 16'($urandom);
            program_all(sp,
                        16'(($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 12000)),
                        16'(($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 4000)),
                        16'(($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 12000)),
                        4'($urandom_range(0, 15)), 16'($urandom_range(0, 30)),
                        16'($urandom_range(0, 40)), 16'($urandom));
            for (int k = 0; k < PHASE_SAMPLES; k++) begin
                case ($urandom_range(0, 9))
                    0:       m = $urandom_range(0, 1) ? 32767 : -32768;
                    1, 2:    m = int'($signed(16'($urandom)));
                    default: m = int'(sp) + int'($urandom_range(0, 1023)) - 512;
                endcase
                if (m > 32767) m = 32767;
                if (m < -32768) m = -32768;
                queue_sample(16'(m), (k == 0) || ($urandom_range(0, 39) == 0));
            end
            if (p == 2) hold_req = ~hold_req;
            drain();
        end

        drain();
        $display("covered %0d samples, %0d results checked, %0d register writes;",
                 samples_taken, results_taken, cfg_taken);
        $display("clamps at both limits, restarts, full-rate bursts, a long output hold");
        if (failures == 0) begin
            $display("** pid_controller_with_disturbance: PASSED **");
        end else begin
            $display("** pid_controller_with_disturbance: FAILED **");
        end
        $finish;
    end

endmodule
